FILE: design/scfs_pkg.sv
// Shared types and constants of the serial command frame slave.
package scfs_pkg;

    typedef enum logic [2:0] {
        KIND_NOTHING  = 3'd0,
        KIND_SERVO1   = 3'd1,
        KIND_SERVO2   = 3'd2,
        KIND_SPEED    = 3'd3,
        KIND_MOVE     = 3'd4,
        KIND_REPLY    = 3'd5,
        KIND_CHECKSUM = 3'd6,
        KIND_FRAMING  = 3'd7
    } kind_t;

    localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_SERVO_ONE_BASE = 2'd1;
    localparam logic [1:0] CFG_SERVO_TWO_BASE = 2'd2;

    localparam logic [7:0] START_BYTE = 8'hFF;

    localparam logic [2:0] REPLY_LAST_BEAT = 3'd6;

    // One decoded item: a single result, or a reply frame sent over seven beats
    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [7:0]  move_dir;
        logic        reply;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [7:0]  data_hi;
        logic [7:0]  data_lo;
        logic [7:0]  sum;
    } desc_t;

endpackage

FILE: design/scfs_channels.sv
// Handshake channel interfaces for received bytes and results.
interface scfs_rx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [15:0] steps_left;
    logic [7:0]  dir_now;

    modport source (output valid, rx_byte, steps_left, dir_now, input ready);
    modport sink   (input valid, rx_byte, steps_left, dir_now, output ready);
endinterface

interface scfs_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] value;
    logic [7:0]  move_dir;
    logic        last;

    modport source (output valid, kind, value, move_dir, last, input ready);
    modport sink   (input valid, kind, value, move_dir, last, output ready);
endinterface

FILE: design/scfs_decode.sv
// Frame receiver state and command decode, one byte per advance.
module scfs_decode
    import scfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] steps_left,
    input  logic [7:0]  dir_now,
    input  logic [7:0]  own_address,
    input  logic [15:0] servo_one_base,
    input  logic [15:0] servo_two_base,
    output desc_t       desc
);

    localparam logic [7:0] CMD_SERVO1_SET   = 8'h1C;
    localparam logic [7:0] CMD_SERVO2_SET   = 8'hBC;
    localparam logic [7:0] CMD_SPEED_SET    = 8'h5C;
    localparam logic [7:0] CMD_MOVE         = 8'h9C;
    localparam logic [7:0] CMD_DIR_SET      = 8'h7C;
    localparam logic [7:0] CMD_SERVO1_QUERY = 8'h1F;
    localparam logic [7:0] CMD_SERVO2_QUERY = 8'hBF;
    localparam logic [7:0] CMD_SPEED_QUERY  = 8'h5F;
    localparam logic [7:0] CMD_STEPS_QUERY  = 8'h9F;
    localparam logic [7:0] CMD_DIR_QUERY    = 8'h7F;

    localparam logic [7:0] RSP_SERVO1 = 8'h17;
    localparam logic [7:0] RSP_SERVO2 = 8'hB7;
    localparam logic [7:0] RSP_SPEED  = 8'h57;
    localparam logic [7:0] RSP_STEPS  = 8'h97;
    localparam logic [7:0] RSP_DIR    = 8'h77;

    // round(speed * 65535 / 14), half up, truncated to 16 bits
    localparam logic [15:0] SPEED_REPLY [16] = '{
        16'd0,     16'd4681,  16'd9362,  16'd14043,
        16'd18724, 16'd23405, 16'd28086, 16'd32768,
        16'd37449, 16'd42130, 16'd46811, 16'd51492,
        16'd56173, 16'd60854, 16'd65535, 16'd4680
    };

    // floor(100 * a / 9) by reciprocal, exact for 8-bit a
    function automatic logic [15:0] servo_offset(input logic [7:0] a);
        logic [27:0] p;
        p = {20'd0, a} * 28'd728178;
        return {4'd0, p[27:16]};
    endfunction

    // floor(v * 14 / 65535)
    function automatic logic [3:0] speed_from(input logic [15:0] v);
        logic [19:0] x;
        logic [19:0] t;
        x = {4'd0, v} * 20'd14;
        t = x + {16'd0, x[19:16]} + 20'd1;
        return t[19:16];
    endfunction

    logic [2:0]  pos_reg,      pos_next;
    logic        in_frame_reg, in_frame_next;
    logic        addr_ok_reg,  addr_ok_next;
    logic [7:0]  cmd_hi_reg,   cmd_hi_next;
    logic [7:0]  cmd_lo_reg,   cmd_lo_next;
    logic [7:0]  data_hi_reg,  data_hi_next;
    logic [7:0]  data_lo_reg,  data_lo_next;
    logic [7:0]  angle1_reg,   angle1_next;
    logic [7:0]  angle2_reg,   angle2_next;
    logic [3:0]  speed_reg,    speed_next;
    logic [7:0]  dir_reg,      dir_next;
    logic [7:0]  frame_sum;
    logic [15:0] data_word;

    always_comb
    begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        addr_ok_next  = addr_ok_reg;
        cmd_hi_next   = cmd_hi_reg;
        cmd_lo_next   = cmd_lo_reg;
        data_hi_next  = data_hi_reg;
        data_lo_next  = data_lo_reg;
        angle1_next   = angle1_reg;
        angle2_next   = angle2_reg;
        speed_next    = speed_reg;
        dir_next      = dir_reg;
        data_word     = {data_hi_reg, data_lo_reg};
        frame_sum     = cmd_hi_reg + cmd_lo_reg + data_hi_reg + data_lo_reg + own_address;

        desc          = '0;
        desc.kind     = KIND_NOTHING;
        desc.addr     = own_address;

        if (!in_frame_reg || pos_reg == 3'd0 || pos_reg == 3'd7)
        begin
            if (rx_byte == START_BYTE)
            begin
                in_frame_next = 1'b1;
                addr_ok_next  = 1'b0;
                pos_next      = 3'd1;
            end
            else
            begin
                in_frame_next = 1'b0;
                addr_ok_next  = 1'b0;
                pos_next      = 3'd0;
                desc.kind     = KIND_FRAMING;
            end
        end
        else if (pos_reg == 3'd1)
        begin
            addr_ok_next = (rx_byte == own_address);
            pos_next     = 3'd2;
        end
        else if (!addr_ok_reg)
        begin
            if (pos_reg == 3'd6)
            begin
                in_frame_next = 1'b0;
                pos_next      = 3'd0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
        else
        begin
            case (pos_reg)
                3'd2:    cmd_hi_next  = rx_byte;
                3'd3:    cmd_lo_next  = rx_byte;
                3'd4:    data_hi_next = rx_byte;
                3'd5:    data_lo_next = rx_byte;
                default: ;
            endcase
            if (pos_reg != 3'd6)
            begin
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                in_frame_next = 1'b0;
                addr_ok_next  = 1'b0;
                pos_next      = 3'd0;
                if (frame_sum != rx_byte)
                begin
                    desc.kind = KIND_CHECKSUM;
                end
                else
                begin
                    case (cmd_lo_reg)
                        CMD_SERVO1_SET:
                        begin
                            angle1_next = data_lo_reg;
                            desc.kind   = KIND_SERVO1;
                            desc.value  = servo_one_base + servo_offset(data_lo_reg);
                        end
                        CMD_SERVO2_SET:
                        begin
                            angle2_next = data_lo_reg;
                            desc.kind   = KIND_SERVO2;
                            desc.value  = servo_two_base + servo_offset(data_lo_reg);
                        end
                        CMD_SPEED_SET:
                        begin
                            speed_next = speed_from(data_word);
                            desc.kind  = KIND_SPEED;
                            desc.value = {12'd0, speed_next};
                        end
                        CMD_MOVE:
                        begin
                            desc.kind     = KIND_MOVE;
                            desc.value    = data_word;
                            desc.move_dir = dir_reg;
                        end
                        CMD_DIR_SET:
                        begin
                            dir_next      = data_lo_reg;
                            desc.kind     = KIND_MOVE;
                            desc.move_dir = data_lo_reg;
                        end
                        CMD_SERVO1_QUERY:
                        begin
                            desc.reply   = 1'b1;
                            desc.cmd     = RSP_SERVO1;
                            desc.data_lo = angle1_reg;
                        end
                        CMD_SERVO2_QUERY:
                        begin
                            desc.reply   = 1'b1;
                            desc.cmd     = RSP_SERVO2;
                            desc.data_lo = angle2_reg;
                        end
                        CMD_SPEED_QUERY:
                        begin
                            desc.reply   = 1'b1;
                            desc.cmd     = RSP_SPEED;
                            desc.data_hi = SPEED_REPLY[speed_reg][15:8];
                            desc.data_lo = SPEED_REPLY[speed_reg][7:0];
                        end
                        CMD_STEPS_QUERY:
                        begin
                            desc.reply   = 1'b1;
                            desc.cmd     = RSP_STEPS;
                            desc.data_hi = steps_left[15:8];
                            desc.data_lo = steps_left[7:0];
                        end
                        CMD_DIR_QUERY:
                        begin
                            dir_next     = dir_now;
                            desc.reply   = 1'b1;
                            desc.cmd     = RSP_DIR;
                            desc.data_lo = dir_now;
                        end
                        default: ;
                    endcase
                end
            end
        end

        if (desc.reply)
        begin
            desc.kind = KIND_REPLY;
        end
        desc.sum = own_address + desc.cmd + desc.data_hi + desc.data_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            addr_ok_reg  <= 1'b0;
            cmd_hi_reg   <= '0;
            cmd_lo_reg   <= '0;
            data_hi_reg  <= '0;
            data_lo_reg  <= '0;
            angle1_reg   <= '0;
            angle2_reg   <= '0;
            speed_reg    <= '0;
            dir_reg      <= '0;
        end
        else if (advance)
        begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            addr_ok_reg  <= addr_ok_next;
            cmd_hi_reg   <= cmd_hi_next;
            cmd_lo_reg   <= cmd_lo_next;
            data_hi_reg  <= data_hi_next;
            data_lo_reg  <= data_lo_next;
            angle1_reg   <= angle1_next;
            angle2_reg   <= angle2_next;
            speed_reg    <= speed_next;
            dir_reg      <= dir_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && pos_reg == 3'd6 && in_frame_reg |=> !in_frame_reg && pos_reg == 3'd0)
        else $error("frame did not close after its seventh byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> pos_reg != 3'd0 && pos_reg != 3'd7)
        else $error("byte position out of frame range");

    assert property (@(posedge clk) disable iff (!rst_n)
        speed_reg <= 4'd14)
        else $error("stepper speed above fourteen");

endmodule

FILE: design/serial_command_frame_slave.sv
// Top level of the serial command frame slave: input stage, decode, result serialiser.
//
//  channel  dir  handshake      payload
//  rx       in   valid/ready    rx_byte[7:0], steps_left[15:0], dir_now[7:0]
//  res      out  valid/ready    kind[2:0], value[15:0], move_dir[7:0], last
//  cfg      in   cfg_we         cfg_index[1:0], cfg_data[15:0]
//
// Data path: input register, decode, result register.
// One byte per cycle while results are taken; a reply frame holds the
// result register for seven beats, one byte per beat.
// Reset clears the frame receiver, the stored angles, speed and direction.
// Either side may stall at any time; the input register holds one byte
// while a result waits, and the input then stalls.
module serial_command_frame_slave
    import scfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    scfs_rx_if.sink     rx,
    scfs_res_if.source  res
);

    logic [7:0]  own_address_reg;
    logic [15:0] servo_one_base_reg;
    logic [15:0] servo_two_base_reg;

    logic        a_valid_reg;
    logic [7:0]  a_byte_reg;
    logic [15:0] a_steps_reg;
    logic [7:0]  a_dir_reg;

    logic        desc_valid_reg;
    desc_t       desc_reg;
    logic [2:0]  beat_reg;

    desc_t       desc_next;
    logic        out_final;
    logic        desc_free;
    logic        advance;
    logic        rx_take;
    logic [7:0]  reply_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg    <= 8'd1;
            servo_one_base_reg <= 16'd350;
            servo_two_base_reg <= 16'd300;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS:    own_address_reg    <= cfg_data[7:0];
                CFG_SERVO_ONE_BASE: servo_one_base_reg <= cfg_data;
                CFG_SERVO_TWO_BASE: servo_two_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_final = !desc_reg.reply || beat_reg == REPLY_LAST_BEAT;
    assign desc_free = !desc_valid_reg || (res.ready && out_final);
    assign advance   = a_valid_reg && desc_free;
    assign rx.ready  = !a_valid_reg || advance;
    assign rx_take   = rx.valid && rx.ready;

    scfs_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .rx_byte        (a_byte_reg),
        .steps_left     (a_steps_reg),
        .dir_now        (a_dir_reg),
        .own_address    (own_address_reg),
        .servo_one_base (servo_one_base_reg),
        .servo_two_base (servo_two_base_reg),
        .desc           (desc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            desc_valid_reg <= 1'b0;
            beat_reg       <= '0;
        end
        else
        begin
            if (rx_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                desc_valid_reg <= 1'b1;
                beat_reg       <= '0;
            end
            else if (desc_valid_reg && res.ready)
            begin
                if (out_final)
                begin
                    desc_valid_reg <= 1'b0;
                end
                else
                begin
                    beat_reg <= beat_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            a_byte_reg  <= rx.rx_byte;
            a_steps_reg <= rx.steps_left;
            a_dir_reg   <= rx.dir_now;
        end
        if (advance)
        begin
            desc_reg <= desc_next;
        end
    end

    always_comb
    begin
        case (beat_reg)
            3'd0:    reply_byte = START_BYTE;
            3'd1:    reply_byte = desc_reg.addr;
            3'd2:    reply_byte = 8'h00;
            3'd3:    reply_byte = desc_reg.cmd;
            3'd4:    reply_byte = desc_reg.data_hi;
            3'd5:    reply_byte = desc_reg.data_lo;
            default: reply_byte = desc_reg.sum;
        endcase
    end

    assign res.valid    = desc_valid_reg;
    assign res.kind     = desc_reg.kind;
    assign res.value    = desc_reg.reply ? {8'd0, reply_byte} : desc_reg.value;
    assign res.move_dir = desc_reg.move_dir;
    assign res.last     = out_final;

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg && !desc_reg.reply |-> beat_reg == 3'd0)
        else $error("beat count moved on a single result");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg && desc_reg.reply && res.ready && beat_reg != REPLY_LAST_BEAT
        |=> desc_valid_reg && beat_reg == $past(beat_reg) + 3'd1)
        else $error("reply frame beat skipped or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg && res.ready && out_final && !advance |=> !desc_valid_reg)
        else $error("result repeated after its last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> rx.ready)
        else $error("input stage empty but not ready");

endmodule
